### sv/frml_pkg.sv
// Shared types and constants for the frame rate meter and limiter.
package frml_pkg;

	localparam int unsigned TICK_W     = 32;
	localparam int unsigned IVL_W      = 16;
	localparam int unsigned RATE_W     = 18;
	localparam int unsigned WAIT_W     = 10;
	localparam int unsigned FPS_W      = 10;
	localparam int unsigned PERIOD_W   = 10;
	localparam int unsigned ADDR_W     = 2;
	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned IN_DATA_W  = 64;
	localparam int unsigned OUT_DATA_W = 48;

	localparam logic [IVL_W-1:0]    INTERVAL_MAX  = 16'hFFFF;
	localparam logic [RATE_W-1:0]   RATE_MAX      = 18'h3FFFF;
	localparam logic [RATE_W-1:0]   RATE_DEFAULT  = 18'd15360;
	localparam logic [FPS_W-1:0]    MAX_FPS_RESET = 10'd60;
	localparam logic [PERIOD_W-1:0] MS_PER_SEC    = 10'd1000;
	// 1000 ms per second times 256 for Q10.8
	localparam int unsigned         RATE_NUM_STEP = 256000;

	localparam logic [ADDR_W-1:0] REG_MAX_FPS = 2'd0;

	typedef struct packed {
		logic capture;
		logic sum_update;
		logic div_load_period;
		logic div_load_rate;
		logic div_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

### sv/frml_ctrl.sv
// Controller state machine that sequences capture, window update, divisions and output.
module frml_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	output frml_pkg::cmd_t   cmd,
	input  frml_pkg::sts_t   sts
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_SUM   = 7'b0000010,
		S_PLOAD = 7'b0000100,
		S_PDIV  = 7'b0001000,
		S_RLOAD = 7'b0010000,
		S_RDIV  = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = S_SUM;
				end
			end
			S_SUM: begin
				cmd.sum_update = 1'b1;
				state_d        = S_PLOAD;
			end
			S_PLOAD: begin
				cmd.div_load_period = 1'b1;
				state_d             = S_PDIV;
			end
			S_PDIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					state_d = S_RLOAD;
				end
			end
			S_RLOAD: begin
				// save the period and reuse the divider for the rate
				cmd.div_load_rate = 1'b1;
				state_d           = S_RDIV;
			end
			S_RDIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign s_axis_tready = (state_q == S_IDLE);

endmodule

### sv/frml_dp.sv
// Datapath: interval window, running sum, shared bit-serial divider and output register.
module frml_dp #(
	parameter int unsigned WINDOW = 10
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  frml_pkg::cmd_t                       cmd,
	output frml_pkg::sts_t                       sts,
	input  logic [frml_pkg::FPS_W-1:0]           max_fps,
	input  logic [frml_pkg::TICK_W-1:0]          start_ticks,
	input  logic [frml_pkg::TICK_W-1:0]          now_ticks,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [frml_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

	localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
	localparam int unsigned SUM_W  = frml_pkg::IVL_W + CNT_W;
	localparam int unsigned NUM_W  = $clog2(WINDOW * frml_pkg::RATE_NUM_STEP + 1);
	localparam int unsigned DCNT_W = $clog2(NUM_W + 1);
	localparam int unsigned PAD_W  = frml_pkg::OUT_DATA_W - frml_pkg::RATE_W
		- frml_pkg::WAIT_W - frml_pkg::IVL_W;
	localparam int unsigned PERIOD_W_L = frml_pkg::PERIOD_W;

	// frame timing state
	logic [frml_pkg::TICK_W-1:0] last_end_q;
	logic                        seen_q;
	logic [frml_pkg::TICK_W-1:0] elapsed_q;
	logic [frml_pkg::IVL_W-1:0]  interval_q;
	logic [frml_pkg::IVL_W-1:0]  old_q;
	logic [frml_pkg::TICK_W-1:0] delta;
	logic [frml_pkg::IVL_W-1:0]  interval_new;

	// window store
	logic [frml_pkg::IVL_W-1:0]  win_mem [WINDOW];
	logic [WINDOW-1:0]           win_vld_q;
	logic [SLOT_W-1:0]           slot_q;
	logic [CNT_W-1:0]            filled_q;
	logic [SUM_W-1:0]            sum_q;

	// divider
	logic [SUM_W-1:0]            div_rem_q;
	logic [NUM_W-1:0]            div_quo_q;
	logic [SUM_W-1:0]            div_den_q;
	logic [DCNT_W-1:0]           div_cnt_q;
	logic [SUM_W:0]              div_shift;
	logic [SUM_W:0]              div_diff;
	logic                        div_ge;
	logic [frml_pkg::FPS_W-1:0]  fps_eff;
	logic [PERIOD_W_L-1:0]       period_q;

	// output register
	logic                         out_vld_q;
	logic [frml_pkg::RATE_W-1:0]  out_rate_q;
	logic [frml_pkg::WAIT_W-1:0]  out_wait_q;
	logic [frml_pkg::IVL_W-1:0]   out_ivl_q;
	logic [frml_pkg::RATE_W-1:0]  rate_fin;
	logic [frml_pkg::WAIT_W-1:0]  wait_fin;

	assign delta = now_ticks - last_end_q;

	always_comb begin
		if (!seen_q) begin
			interval_new = '0;
		end else if (delta > frml_pkg::TICK_W'(frml_pkg::INTERVAL_MAX)) begin
			interval_new = frml_pkg::INTERVAL_MAX;
		end else begin
			interval_new = delta[frml_pkg::IVL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_end_q <= '0;
			seen_q     <= 1'b0;
			win_vld_q  <= '0;
			slot_q     <= '0;
			filled_q   <= '0;
			sum_q      <= '0;
		end else begin
			if (cmd.capture) begin
				last_end_q        <= now_ticks;
				seen_q            <= 1'b1;
				win_vld_q[slot_q] <= 1'b1;
				slot_q            <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
				if (filled_q != CNT_W'(WINDOW)) begin
					filled_q <= filled_q + 1'b1;
				end
			end
			if (cmd.sum_update) begin
				sum_q <= sum_q - SUM_W'(old_q) + SUM_W'(interval_q);
			end
		end
	end

	// read old entry and write new one at the same slot
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			win_mem[slot_q] <= interval_new;
			old_q           <= win_vld_q[slot_q] ? win_mem[slot_q] : '0;
			interval_q      <= interval_new;
			elapsed_q       <= now_ticks - start_ticks;
		end
	end

	assign fps_eff   = (max_fps == '0) ? frml_pkg::FPS_W'(1) : max_fps;
	assign div_shift = {div_rem_q, div_quo_q[NUM_W-1]};
	assign div_ge    = (div_shift >= {1'b0, div_den_q});
	assign div_diff  = div_shift - {1'b0, div_den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.div_load_period) begin
			div_cnt_q <= DCNT_W'(frml_pkg::PERIOD_W);
		end else if (cmd.div_load_rate) begin
			div_cnt_q <= DCNT_W'(NUM_W);
		end else if (cmd.div_step && div_cnt_q != '0) begin
			div_cnt_q <= div_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load_period) begin
			div_rem_q <= '0;
			// left-align the dividend so only its ten bits are stepped through
			div_quo_q <= NUM_W'(frml_pkg::MS_PER_SEC) << (NUM_W - frml_pkg::PERIOD_W);
			div_den_q <= SUM_W'(fps_eff);
		end else if (cmd.div_load_rate) begin
			period_q  <= div_quo_q[PERIOD_W_L-1:0];
			div_rem_q <= '0;
			div_quo_q <= NUM_W'(filled_q) * NUM_W'(frml_pkg::RATE_NUM_STEP);
			div_den_q <= sum_q;
		end else if (cmd.div_step && div_cnt_q != '0) begin
			div_rem_q <= div_ge ? div_diff[SUM_W-1:0] : div_shift[SUM_W-1:0];
			div_quo_q <= {div_quo_q[NUM_W-2:0], div_ge};
		end
	end

	always_comb begin
		if (sum_q == '0) begin
			rate_fin = frml_pkg::RATE_DEFAULT;
		end else if (div_quo_q > NUM_W'(frml_pkg::RATE_MAX)) begin
			rate_fin = frml_pkg::RATE_MAX;
		end else begin
			rate_fin = div_quo_q[frml_pkg::RATE_W-1:0];
		end
		if (elapsed_q < frml_pkg::TICK_W'(period_q)) begin
			wait_fin = period_q - elapsed_q[frml_pkg::WAIT_W-1:0];
		end else begin
			wait_fin = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_rate_q <= rate_fin;
			out_wait_q <= wait_fin;
			out_ivl_q  <= interval_q;
		end
	end

	assign sts.div_done  = (div_cnt_q == '0);
	assign sts.out_free  = !out_vld_q || m_axis_tready;
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {{PAD_W{1'b0}}, out_ivl_q, out_wait_q, out_rate_q};

`ifndef ASSERT_OFF
	a_slot_tracks_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(filled_q < CNT_W'(WINDOW)) |-> (CNT_W'(slot_q) == filled_q))
		else $error("write slot out of step with fill count");

	a_first_interval_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.capture && !seen_q) |=> (interval_q == '0))
		else $error("first frame interval not zero");

	a_out_after_divide: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (div_cnt_q == '0))
		else $error("result loaded while divider busy");
`endif

endmodule

### sv/frame_rate_meter_limiter_core.sv
// Sequence: a frame event is captured, the window sum is updated, then the shared bit-serial
// divider runs the ten-step period division and the NUM_W-step rate division, where
// NUM_W = clog2(256000*WINDOW + 1); the result is then loaded into the output register.
// A new frame event is accepted only once the previous result is in the output register.
// Reset (arst_n low, asynchronous): window cleared through per-entry valid bits,
// sum, count and tick history zeroed, max_fps set to 60; no clearing pass.
module frame_rate_meter_limiter_core #(
	parameter int unsigned WINDOW = 10
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// APB configuration port
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [frml_pkg::ADDR_W-1:0]           paddr,
	input  logic [frml_pkg::APB_DATA_W-1:0]       pwdata,
	output logic [frml_pkg::APB_DATA_W-1:0]       prdata,
	output logic                                  pready,
	// frame-end events
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [frml_pkg::IN_DATA_W-1:0]        s_axis_tdata,  // start_ticks, now_ticks
	// results
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [frml_pkg::OUT_DATA_W-1:0]       m_axis_tdata   // rate_q8, wait_ms, interval_ms
);

	logic [frml_pkg::FPS_W-1:0] max_fps_q;
	frml_pkg::cmd_t             cmd;
	frml_pkg::sts_t             sts;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_fps_q <= frml_pkg::MAX_FPS_RESET;
		end else if (psel && penable && pwrite && pready && paddr == frml_pkg::REG_MAX_FPS) begin
			max_fps_q <= pwdata[frml_pkg::FPS_W-1:0];
		end
	end

	always_comb begin
		unique case (paddr)
			frml_pkg::REG_MAX_FPS: prdata = frml_pkg::APB_DATA_W'(max_fps_q);
			default:               prdata = '0;
		endcase
	end

	frml_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.cmd           (cmd),
		.sts           (sts)
	);

	frml_dp #(
		.WINDOW (WINDOW)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.max_fps       (max_fps_q),
		.start_ticks   (s_axis_tdata[frml_pkg::TICK_W-1:0]),
		.now_ticks     (s_axis_tdata[2*frml_pkg::TICK_W-1:frml_pkg::TICK_W]),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

### test/frame_rate_meter_limiter_core_test.sv
// Self-checking testbench for the frame rate meter and limiter core.
module frame_rate_meter_limiter_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import frml_pkg::*;

	localparam int unsigned WINDOW = 10;
	localparam int unsigned LONG_STALL = 400;

	typedef struct {
		logic [RATE_W-1:0] rate_q8;
		logic [WAIT_W-1:0] wait_ms;
		logic [IVL_W-1:0]  interval_ms;
	} frame_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [ADDR_W-1:0]     paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // start_ticks, now_ticks
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;        // rate_q8, wait_ms, interval_ms

	// frame events waiting to be driven, results waiting to arrive
	logic [IN_DATA_W-1:0] frames_pending[$];
	frame_result_t        meter_results_due[$];

	// predictor state
	logic [FPS_W-1:0] fps_cfg = MAX_FPS_RESET;
	logic [TICK_W-1:0] last_end_tick = '0;
	logic              seen_first = 1'b0;
	logic [IVL_W-1:0]  ivl_window[WINDOW];
	int unsigned       write_slot = 0;
	int unsigned       filled_count = 0;
	logic [21:0]       window_sum = '0;

	int unsigned mismatch_count = 0;
	logic        in_taken = 1'b0;
	logic        out_taken = 1'b0;
	int unsigned send_gap = 0;
	int unsigned send_gap_max = 7;
	int unsigned recv_wait = 0;
	int unsigned recv_gap_max = 7;
	int unsigned stall_req = 0;
	int unsigned stall_ack = 0;
	int unsigned stall_left = 0;
	logic [TICK_W-1:0] tick_now = '0;

	frame_rate_meter_limiter_core #(.WINDOW(WINDOW)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #1 clk = ~clk;

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		$display("mismatch in %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	function automatic void measure_frame(input logic [IN_DATA_W-1:0] frame);
		logic [TICK_W-1:0] start_t;
		logic [TICK_W-1:0] now_t;
		logic [TICK_W-1:0] gap;
		logic [TICK_W-1:0] elapsed;
		logic [IVL_W-1:0]  ivl;
		logic [IVL_W-1:0]  old;
		logic [63:0]       quo;
		int unsigned       fps_eff;
		int unsigned       period;
		frame_result_t     r;
		start_t = frame[TICK_W-1:0];
		now_t = frame[2*TICK_W-1:TICK_W];
		if (seen_first) begin
			gap = now_t - last_end_tick;
			ivl = (gap > INTERVAL_MAX) ? INTERVAL_MAX : gap[IVL_W-1:0];
		end else begin
			ivl = '0;
			seen_first = 1'b1;
		end
		last_end_tick = now_t;
		old = ivl_window[write_slot];
		ivl_window[write_slot] = ivl;
		window_sum = window_sum - old + ivl;
		write_slot = (write_slot + 1 >= WINDOW) ? 0 : write_slot + 1;
		if (filled_count < WINDOW)
			filled_count++;
		if (window_sum == 0) begin
			r.rate_q8 = RATE_DEFAULT;
		end else begin
			quo = (64'(RATE_NUM_STEP) * filled_count) / window_sum;
			r.rate_q8 = (quo > RATE_MAX) ? RATE_MAX : quo[RATE_W-1:0];
		end
		// zero max_fps counts as one frame per second
		fps_eff = (fps_cfg == 0) ? 1 : fps_cfg;
		period = MS_PER_SEC / fps_eff;
		elapsed = now_t - start_t;
		r.wait_ms = (elapsed < period) ? WAIT_W'(period - elapsed) : '0;
		r.interval_ms = ivl;
		meter_results_due.push_back(r);
	endfunction

	// input side: drive at the falling edge, hold until the transaction completes
	always @(negedge clk) begin : frame_source
		logic                 nv;
		logic [IN_DATA_W-1:0] nd;
		nv = s_axis_tvalid;
		nd = s_axis_tdata;
		if (arst_n && !(s_axis_tvalid && !in_taken)) begin
			nv = 1'b0;
			if (send_gap != 0) begin
				send_gap <= send_gap - 1;
			end else if (frames_pending.size() != 0) begin
				nd = frames_pending.pop_front();
				nv = 1'b1;
				send_gap <= $urandom_range(0, send_gap_max);
			end
		end
		s_axis_tvalid <= nv;
		s_axis_tdata <= nd;
	end

	// output side: random back-pressure, plus one long hold-off on request
	always @(negedge clk) begin : result_sink
		int unsigned w;
		w = out_taken ? $urandom_range(0, recv_gap_max) : recv_wait;
		if (stall_ack != stall_req) begin
			stall_ack <= stall_req;
			stall_left <= LONG_STALL;
			recv_wait <= w;
			m_axis_tready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			recv_wait <= w;
			m_axis_tready <= 1'b0;
		end else if (w != 0) begin
			recv_wait <= w - 1;
			m_axis_tready <= 1'b0;
		end else begin
			recv_wait <= 0;
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : monitor
		frame_result_t want;
		in_taken <= arst_n && s_axis_tvalid && s_axis_tready;
		out_taken <= arst_n && m_axis_tvalid && m_axis_tready;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (meter_results_due.size() == 0) begin
				report_mismatch("unexpected result", m_axis_tdata, 0);
			end else begin
				want = meter_results_due.pop_front();
				if (m_axis_tdata[RATE_W-1:0] !== want.rate_q8)
					report_mismatch("rate_q8", m_axis_tdata[RATE_W-1:0], want.rate_q8);
				if (m_axis_tdata[RATE_W+WAIT_W-1:RATE_W] !== want.wait_ms)
					report_mismatch("wait_ms", m_axis_tdata[RATE_W+WAIT_W-1:RATE_W],
						want.wait_ms);
				if (m_axis_tdata[RATE_W+WAIT_W+IVL_W-1:RATE_W+WAIT_W] !== want.interval_ms)
					report_mismatch("interval_ms",
						m_axis_tdata[RATE_W+WAIT_W+IVL_W-1:RATE_W+WAIT_W], want.interval_ms);
			end
		end
		if (arst_n && s_axis_tvalid && s_axis_tready)
			measure_frame(s_axis_tdata);
	end

	task automatic queue_frame(input logic [TICK_W-1:0] start_t, input logic [TICK_W-1:0] now_t);
		frames_pending.push_back({now_t, start_t});
		tick_now = now_t;
	endtask

	// mostly a running clock with plausible intervals, some noise
	task automatic queue_random_frames(input int unsigned n);
		int unsigned       sel;
		int unsigned       period;
		logic [TICK_W-1:0] ivl;
		logic [TICK_W-1:0] elapsed;
		period = MS_PER_SEC / ((fps_cfg == 0) ? 1 : fps_cfg);
		repeat (n) begin
			if ($urandom_range(0, 4) == 0) begin
				queue_frame($urandom, $urandom);
			end else begin
				sel = $urandom_range(0, 9);
				if (sel < 7)
					ivl = $urandom_range(1, 50);
				else if (sel == 7)
					ivl = 0;
				else if (sel == 8)
					ivl = $urandom_range(51, 70000);
				else
					ivl = $urandom;
				sel = $urandom_range(0, 9);
				if (sel < 7)
					elapsed = $urandom_range(0, period + 3);
				else if (sel < 9)
					elapsed = $urandom_range(0, 40);
				else
					elapsed = $urandom;
				queue_frame(tick_now + ivl - elapsed, tick_now + ivl);
			end
		end
	endtask

	// hold until every queued frame has been sent and answered; sample at the rising
	// edge, where the driven valid is settled
	task automatic drain();
		@(posedge clk);
		while (frames_pending.size() != 0 || s_axis_tvalid || meter_results_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_max_fps(input logic [FPS_W-1:0] v);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_MAX_FPS;
		// upper bits are don't-care for a 10-bit register
		pwdata <= {APB_DATA_W'($urandom) & ~APB_DATA_W'(10'h3FF)} | APB_DATA_W'(v);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		fps_cfg = v;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic check_max_fps(input logic [FPS_W-1:0] want);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= REG_MAX_FPS;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata[FPS_W-1:0] !== want)
			report_mismatch("max_fps read", prdata[FPS_W-1:0], want);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin : stimulus
		logic [FPS_W-1:0] fps_plan[8];
		int unsigned      elapsed;
		for (int i = 0; i < WINDOW; i++)
			ivl_window[i] = '0;
		fps_plan = '{10'd1, 10'd1000, 10'd0, 10'd1023, 10'd60, 10'd0, 10'd0, 10'd0};
		for (int i = 5; i < 8; i++)
			fps_plan[i] = $urandom_range(0, 1023);
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		check_max_fps(MAX_FPS_RESET);

		// directed frames at the reset rate limit
		queue_frame(32'h0, 32'h0);                // first event
		queue_frame(32'h0, 32'h0);                // sum still zero
		queue_frame(32'h0, 32'h1);                // average below 1 ms, rate saturates
		queue_frame(32'hFFFF_FFFF, 32'h1);        // elapsed wraps
		queue_frame(32'h1, 32'd70000);            // interval saturates
		queue_frame(32'h0, 32'hFFFF_FFFF);        // huge elapsed, no wait
		queue_frame(32'hFFFF_FFF0, 32'h5);        // interval wraps
		for (int i = 0; i < 14; i++) begin
			elapsed = (i < 3) ? 15 + i : i;
			queue_frame(tick_now + 16 - elapsed, tick_now + 16);
		end
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			write_max_fps(fps_plan[ph]);
			check_max_fps(fps_plan[ph]);
			send_gap_max = (ph % 3 == 2) ? 0 : 7;
			recv_gap_max = (ph % 3 == 2) ? 0 : 7;
			if (ph == 1) begin
				// fill the block while the output is held off
				send_gap_max = 0;
				stall_req++;
			end
			queue_random_frames(225);
			drain();
		end

		repeat (100) @(posedge clk);
		if (mismatch_count == 0 && meter_results_due.size() == 0) begin
			$display("frame_rate_meter_limiter_core_test: PASS");
		end else begin
			$display("frame_rate_meter_limiter_core_test: FAIL");
		end
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("frame_rate_meter_limiter_core_test: FAIL");
		$finish;
	end

endmodule
